FILE: rtl/rmp_pkg.sv
// Shared types and constants for the running median / percentile filter.
// Used by rmp_cell, rmp_stats and running_median_percentile; no dependencies.
package rmp_pkg;

  localparam int WINDOW   = 9;
  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 17;
  localparam int FRAC_ONE = 65536;
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int AGE_W    = IDX_W;
  localparam int FILL_W   = 4;
  localparam int OUT_W    = 40;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // one sorted-list slot: value, age in the window, occupied
  typedef struct packed {
    sample_t            val;
    logic [AGE_W-1:0]   age;
    logic               vld;
  } slot_t;

  // link handed from cell i to cell i+1
  typedef struct packed {
    slot_t lp;     // list entry i after removal
    logic  rm_le;  // removal at or left of cell i
    logic  lt;     // entry i after removal is below the new sample
  } fwd_t;

  typedef struct packed {
    sample_t             median;
    sample_t             pct;
    logic [FILL_W-1:0]   fill;
    logic                full;
  } result_t;

endpackage

FILE: rtl/rmp_cell.sv
// One cell of the sorted chain: holds one ordered sample and its age.
// Depends on rmp_pkg.
module rmp_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic            full,
  input  rmp_pkg::sample_t sample,
  input  rmp_pkg::fwd_t   left,
  input  rmp_pkg::slot_t  right,
  output rmp_pkg::fwd_t   to_right,
  output rmp_pkg::slot_t  held
);
  import rmp_pkg::*;

  slot_t cur;
  slot_t cur_next;
  logic  rm;

  always_comb begin
    rm             = full && cur.vld && (cur.age == AGE_W'(WINDOW - 1));
    to_right.rm_le = left.rm_le | rm;
    to_right.lp    = to_right.rm_le ? right : cur;
    to_right.lt    = to_right.lp.vld && ($signed(to_right.lp.val) < $signed(sample));
  end

  // keep entry i after removal (own, or shifted in from the right), take the new sample, or shift in from the left
  always_comb begin
    if (to_right.lt) begin
      cur_next     = to_right.lp;
      cur_next.age = to_right.lp.age + AGE_W'(1);
    end else if (left.lt) begin
      cur_next.val = sample;
      cur_next.age = '0;
      cur_next.vld = 1'b1;
    end else begin
      cur_next     = left.lp;
      cur_next.age = left.lp.age + AGE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.vld <= 1'b0;
    end else if (load) begin
      cur <= cur_next;
    end
  end

  assign held = cur;

endmodule

FILE: rtl/rmp_stats.sv
// Median and interpolated percentile over the sorted chain, three stages.
// Depends on rmp_pkg.
module rmp_stats (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_vld,
  input  rmp_pkg::sample_t          ord [rmp_pkg::WINDOW],
  input  logic [rmp_pkg::CNT_W-1:0] cnt,
  input  logic [rmp_pkg::FRAC_W-1:0] frac,
  output logic                      out_vld,
  output rmp_pkg::result_t          res
);
  import rmp_pkg::*;

  localparam int P_W = SAMPLE_W + CNT_W;

  logic [CNT_W-1:0]     mid;
  logic [CNT_W-1:0]     nm1;
  logic [P_W-1:0]       p;
  logic [CNT_W-1:0]     lo;
  logic signed [SAMPLE_W:0] pair_sum;
  logic signed [SAMPLE_W:0] diff;
  sample_t              med_a;
  sample_t              base_a;
  logic [SAMPLE_W-1:0]  d_a;
  logic [SAMPLE_W-1:0]  f_a;

  // stage A: selection out of the chain
  always_comb begin
    mid      = cnt >> 1;
    nm1      = cnt - CNT_W'(1);
    pair_sum = '0;
    if (cnt[0]) begin
      med_a = ord[IDX_W'(mid)];
    end else begin
      pair_sum = {ord[IDX_W'(mid - CNT_W'(1))][SAMPLE_W-1], ord[IDX_W'(mid - CNT_W'(1))]}
               + {ord[IDX_W'(mid)][SAMPLE_W-1], ord[IDX_W'(mid)]};
      med_a    = pair_sum[SAMPLE_W:1];
    end

    p    = P_W'(frac[SAMPLE_W-1:0]) * P_W'(nm1);
    lo   = p[SAMPLE_W +: CNT_W];
    diff = '0;
    d_a  = '0;
    f_a  = '0;
    if (cnt <= CNT_W'(1) || frac == '0) begin
      base_a = ord[0];
    end else if (frac >= FRAC_W'(FRAC_ONE) || lo >= nm1) begin
      base_a = ord[IDX_W'(nm1)];
    end else begin
      base_a = ord[IDX_W'(lo)];
      diff   = {ord[IDX_W'(lo + CNT_W'(1))][SAMPLE_W-1], ord[IDX_W'(lo + CNT_W'(1))]}
             - {ord[IDX_W'(lo)][SAMPLE_W-1], ord[IDX_W'(lo)]};
      d_a    = diff[SAMPLE_W-1:0];
      f_a    = p[SAMPLE_W-1:0];
    end
  end

  logic                    a_vld, b_vld;
  sample_t                 a_med, a_base, b_med, b_base;
  logic [SAMPLE_W-1:0]     a_d, a_f, b_q;
  logic [CNT_W-1:0]        a_cnt, b_cnt;
  logic [2*SAMPLE_W-1:0]   prod;

  assign prod = a_f * a_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld   <= 1'b0;
      b_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      a_vld   <= in_vld;
      b_vld   <= a_vld;
      out_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_med    <= med_a;
      a_base   <= base_a;
      a_d      <= d_a;
      a_f      <= f_a;
      a_cnt    <= cnt;
      b_med    <= a_med;
      b_base   <= a_base;
      b_q      <= prod[2*SAMPLE_W-1:SAMPLE_W];
      b_cnt    <= a_cnt;
      res.median <= b_med;
      res.pct    <= b_base + $signed(b_q);
      res.fill   <= FILL_W'(b_cnt);
      res.full   <= (b_cnt == CNT_W'(WINDOW));
    end
  end

endmodule

FILE: rtl/running_median_percentile.sv
// Top level of the running median / percentile filter.
// Depends on rmp_pkg, rmp_cell and rmp_stats.
//
// Usage:
//   Input stream (s_*): one signed 16-bit sample per request.
//   Output stream (m_*): one result per input request, in order: median,
//   interpolated percentile, fill count and full flag over the last WINDOW
//   samples including the one just taken.
//   Config channel (cfg_*): writes the Q16 percentile fraction (17 bits,
//   65536 = 1.0, larger values clamp to the maximum). cfg_ready is always
//   high; write only while no request is in flight.
// Throughput: one request per cycle while the output is not stalled. The
//   sorted chain removes the oldest sample and inserts the new one at once,
//   every cell in parallel, on the accepting edge. Selection, interpolation
//   multiply and final add then follow as registered stages up to m_tvalid.
// Reset: rst (synchronous) empties the window, clears the pipeline and sets
//   the fraction to 0.5.
// Stall: when m_tready is low with a result waiting, the whole pipeline
//   holds and s_tready drops in the same cycle; nothing is lost or repeated.
module running_median_percentile (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [rmp_pkg::SAMPLE_W-1:0] s_tdata,   // [15:0] sample_in
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [rmp_pkg::OUT_W-1:0]   m_tdata,    // [15:0] median_out, [31:16] percentile_out,
                                                  // [35:32] fill_count, [36] window_full, rest 0
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rmp_pkg::FRAC_W-1:0]  cfg_data    // [16:0] percentile_fraction
);
  import rmp_pkg::*;

  logic               en;
  logic               accept;
  logic               full;
  logic               c_vld;      // chain holds a freshly updated list
  logic [CNT_W-1:0]   cnt;
  logic [FRAC_W-1:0]  frac;
  sample_t            sample;
  fwd_t               lnk  [WINDOW+1];
  slot_t              held [WINDOW];
  sample_t            ord  [WINDOW];
  logic [WINDOW-1:0]  vld_vec;
  result_t            res;

  // whole pipeline advances unless a result is stuck at the output
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign sample    = s_tdata;
  assign full      = (cnt == CNT_W'(WINDOW));

  always_ff @(posedge clk) begin
    if (rst) begin
      frac <= FRAC_W'(FRAC_ONE / 2);
    end else if (cfg_valid && cfg_ready) begin
      frac <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= accept;
      if (accept && !full) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // head of chain: nothing removed yet, new sample goes in front by default
  assign lnk[0] = '{lp: '0, rm_le: 1'b0, lt: 1'b1};

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    slot_t right;
    if (i == WINDOW - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = held[i+1];
    end

    rmp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .load     (accept),
      .full     (full),
      .sample   (sample),
      .left     (lnk[i]),
      .right    (right),
      .to_right (lnk[i+1]),
      .held     (held[i])
    );

    assign ord[i]     = held[i].val;
    assign vld_vec[i] = held[i].vld;
  end

  rmp_stats u_stats (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (c_vld),
    .ord     (ord),
    .cnt     (cnt),
    .frac    (frac),
    .out_vld (m_tvalid),
    .res     (res)
  );

  assign m_tdata = {{(OUT_W - 2*SAMPLE_W - FILL_W - 1){1'b0}},
                    res.full, res.fill, res.pct, res.median};

  // occupied cells always match the fill count
  a_cnt_match: assert property (@(posedge clk) disable iff (rst)
    $countones(vld_vec) == int'(cnt))
    else $error("chain occupancy differs from fill count");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(WINDOW))
    else $error("fill count above window size");

  // list end never gets past the tail cell
  a_tail_clear: assert property (@(posedge clk) disable iff (rst)
    !lnk[WINDOW].lp.vld || lnk[WINDOW].rm_le == 1'b0)
    else $error("tail link carries an entry after removal");

  for (genvar k = 0; k + 1 < WINDOW; k++) begin : g_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      held[k+1].vld |-> ($signed(held[k].val) <= $signed(held[k+1].val)))
      else $error("chain out of order");
  end

endmodule

FILE: bench/median_window_checker.sv
// Checker for the running median / percentile filter: mirrors the window,
// predicts each result and compares it with what the output stream delivers.
// Depends on rmp_pkg for widths and the result type.
module median_window_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [rmp_pkg::SAMPLE_W-1:0] s_tdata,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [rmp_pkg::OUT_W-1:0]    m_tdata,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [rmp_pkg::FRAC_W-1:0]   cfg_data,
  output int                           error_count,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NWIN = rmp_pkg::WINDOW;

  int                          arrivals [NWIN];  // samples by arrival slot
  int                          ranked   [NWIN];  // same samples, ascending
  int                          held;
  int                          next_slot;
  logic [rmp_pkg::FRAC_W-1:0]  fraction;
  rmp_pkg::result_t            expected_stats [$];
  int                          result_no;

  // first ranked position not below v
  function automatic int rank_of(input int n, input int v);
    int k;
    k = 0;
    while (k < n && ranked[k] < v) k++;
    return k;
  endfunction

  // slide the window by one sample, return median / percentile / fill / full
  function automatic rmp_pkg::result_t advance_window(input rmp_pkg::sample_t s);
    rmp_pkg::result_t r;
    int n, pos, i, med, pct, frac_pos, lo, f, d;
    n = held;
    if (n == NWIN) begin
      pos = rank_of(n, arrivals[next_slot]);
      if (pos < n) begin
        for (i = pos; i + 1 < n; i++) ranked[i] = ranked[i + 1];
        n--;
      end
    end
    if (n < NWIN) begin
      pos = rank_of(n, int'(s));
      for (i = n; i > pos; i--) ranked[i] = ranked[i - 1];
      ranked[pos] = int'(s);
      n++;
    end
    arrivals[next_slot] = int'(s);
    next_slot = (next_slot + 1 >= NWIN) ? 0 : next_slot + 1;
    held = n;

    if (n % 2 == 1) med = ranked[n / 2];
    else med = (ranked[n / 2 - 1] + ranked[n / 2]) >>> 1;   // floors

    if (n == 1 || fraction == 0) pct = ranked[0];
    else if (fraction >= rmp_pkg::FRAC_ONE) pct = ranked[n - 1];
    else begin
      frac_pos = int'(fraction) * (n - 1);
      lo = frac_pos >> 16;
      f = frac_pos & 16'hFFFF;
      if (lo + 1 >= n) pct = ranked[n - 1];
      else begin
        d = ranked[lo + 1] - ranked[lo];
        pct = ranked[lo] + int'((longint'(f) * longint'(d)) >>> 16);
      end
    end

    r.median = med[15:0];
    r.pct    = pct[15:0];
    r.fill   = n[rmp_pkg::FILL_W-1:0];
    r.full   = (n == NWIN);
    return r;
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      error_count++;
      if (error_count <= 10)
        $display("result %0d: %s expected %0d got %0d", result_no, name, want, got);
    end
  endtask

  task automatic check_result(input logic [rmp_pkg::OUT_W-1:0] word);
    rmp_pkg::result_t want;
    if (expected_stats.size() == 0) begin
      error_count++;
      if (error_count <= 10)
        $display("result %0d: unexpected, data %h", result_no, word);
    end else begin
      want = expected_stats.pop_front();
      compare_field("median", int'(want.median), int'($signed(word[15:0])));
      compare_field("percentile", int'(want.pct), int'($signed(word[31:16])));
      compare_field("fill", int'(want.fill), int'(word[35:32]));
      compare_field("full", int'(want.full), int'(word[36]));
      compare_field("padding", 0, int'(word[rmp_pkg::OUT_W-1:37]));
    end
    result_no++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (arrivals[i]) arrivals[i] = 0;
      foreach (ranked[i]) ranked[i] = 0;
      held        = 0;
      next_slot   = 0;
      fraction    = rmp_pkg::FRAC_W'(32768);
      result_no   = 0;
      error_count = 0;
      expected_stats.delete();
    end else begin
      if (cfg_valid && cfg_ready) fraction = cfg_data;
      if (s_tvalid && s_tready) expected_stats.push_back(advance_window(s_tdata));
      if (m_tvalid && m_tready) check_result(m_tdata);
    end
    pending = expected_stats.size();
  end

endmodule

FILE: bench/tb.sv
// Top of the running median / percentile bench: clock, reset, stimulus and verdict.
// Depends on rmp_pkg, running_median_percentile and median_window_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no request on any channel before the run is declared hung;
  // worst honest gap is a long sender idle run stacked on a long receiver
  // stall, the busier of the two sides idling at 70%
  localparam int QUIET_LIMIT = 4000;
  // pipeline is 4 deep; wait well past that depth for stray results at the end
  localparam int DRAIN_CYCLES = 16;
  localparam int SEGMENT_ITEMS = 170;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [rmp_pkg::SAMPLE_W-1:0] s_tdata = '0;   // [15:0] sample_in
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [rmp_pkg::OUT_W-1:0]    m_tdata;        // [15:0] median, [31:16] percentile,
                                                // [35:32] fill, [36] full
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [rmp_pkg::FRAC_W-1:0]   cfg_data = '0;  // [16:0] percentile_fraction

  int error_count;
  int pending;
  int tx_idle_pct = 20;   // chance per cycle that the sender holds back
  int rx_idle_pct = 70;   // chance per cycle that the receiver stalls
  int quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  running_median_percentile dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  median_window_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .error_count(error_count),
    .pending    (pending)
  );

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // hang detector: any accepted request on any channel resets the count
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one sample. Called at a falling edge, returns at the falling edge
  // after acceptance with s_tvalid still high, so back-to-back requests never
  // drop valid. Idle cycles, if any, come first and carry junk data.
  task automatic push_sample(input logic [rmp_pkg::SAMPLE_W-1:0] v);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 16'($urandom);
      do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Fraction change: input goes quiet and every result must be back first,
  // so the new setting never lands on a sample already in flight.
  task automatic write_fraction(input logic [rmp_pkg::FRAC_W-1:0] f);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= f;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mix: full-range values, a tight cluster for ties and duplicate removal,
  // the rails, and a moderate band around zero for sign handling.
  function automatic logic [rmp_pkg::SAMPLE_W-1:0] random_sample();
    int kind;
    kind = $urandom_range(99);
    if (kind < 40) return 16'($urandom);
    if (kind < 70) return 16'($urandom_range(8)) - 16'd4;
    if (kind < 80) begin
      case ($urandom_range(3))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        2:       return 16'h8001;
        default: return 16'h7FFE;
      endcase
    end
    return 16'($urandom_range(600)) - 16'd300;
  endfunction

  // Fraction settings: both ends, the clamp range, and the interior.
  function automatic logic [rmp_pkg::FRAC_W-1:0] pick_fraction();
    case ($urandom_range(6))
      0:       return '0;
      1:       return 17'd65536;
      2:       return 17'd131071;
      3:       return 17'($urandom_range(131071, 65537));
      4:       return 17'($urandom_range(3, 1));
      5:       return 17'd65535;
      default: return 17'($urandom_range(65535));
    endcase
  endfunction

  initial begin
    // Opening run at the reset fraction of one half: single sample, rail
    // values, even-count floor averaging, filling to full, equal values on
    // insert and on removal.
    int opening [13] = '{100, -32768, 32767, 0, -1, 1, 5, 5, 5, -32768, 5, 32767, -3};
    int seg;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (opening[k]) push_sample(opening[k][15:0]);

    // fraction zero: percentile is the minimum
    write_fraction('0);
    push_sample(16'hFFF9);
    push_sample(16'h7FFF);
    // exactly one: clamps to the maximum
    write_fraction(17'd65536);
    push_sample(16'h8000);
    push_sample(16'd8);
    // top of the register range, still clamped
    write_fraction(17'd131071);
    push_sample(16'd3);
    push_sample(16'h8001);
    // just below one: last interpolation step, widest spread
    write_fraction(17'd65535);
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    // smallest nonzero step
    write_fraction(17'd1);
    push_sample(16'd12345);

    // Random part in six segments, a new fraction for each; idle profile
    // goes sender-light/receiver-heavy, then the reverse, then none.
    for (seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        tx_idle_pct = 70;
        rx_idle_pct = 20;
      end
      if (seg == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_fraction(pick_fraction());
      repeat (SEGMENT_ITEMS) push_sample(random_sample());
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rmp_pkg.sv
rtl/rmp_cell.sv
rtl/rmp_stats.sv
rtl/running_median_percentile.sv
bench/median_window_checker.sv
bench/tb.sv
